>>> sv/differential_manchester_transmitter_defines.svh
// ---------------------------------------------------------------------------
// differential manchester transmitter assertion macros
// concurrent checks, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef DIFFERENTIAL_MANCHESTER_TRANSMITTER_DEFINES_SVH
`define DIFFERENTIAL_MANCHESTER_TRANSMITTER_DEFINES_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge out of reset
`define DMT_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("dmt assertion failed");

// consequent holds in the cycle after the antecedent
`define DMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmt assertion failed");

`else

`define DMT_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define DMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/dmt_pkg.sv
// ---------------------------------------------------------------------------
// dmt_pkg
// shared types and constants of the differential manchester transmitter
// ---------------------------------------------------------------------------
package dmt_pkg;

    localparam int DataW   = 8;
    localparam int TopBit  = 7;
    localparam int BitIdxW = $clog2(TopBit + 1);

    // item queue between front and back
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef struct packed {
        logic [DataW-1:0] data_byte;
        logic             first_byte;
        logic             last_byte;
    } item_t;

    // head of the item queue as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

>>> sv/dmt_front.sv
// ---------------------------------------------------------------------------
// dmt_front
// accepts items and holds them in a short queue for the encoder
// ---------------------------------------------------------------------------
`include "differential_manchester_transmitter_defines.svh"

module dmt_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  dmt_pkg::item_t        item_in,
    output dmt_pkg::head_t        head,
    input  logic                  take
);

    dmt_pkg::item_t                  entry_reg [dmt_pkg::QDepth];
    logic [dmt_pkg::QPtrW-1:0]       wr_ptr_reg;
    logic [dmt_pkg::QPtrW-1:0]       wr_ptr_next;
    logic [dmt_pkg::QPtrW-1:0]       rd_ptr_reg;
    logic [dmt_pkg::QPtrW-1:0]       rd_ptr_next;
    logic [dmt_pkg::QCntW-1:0]       count_reg;
    logic [dmt_pkg::QCntW-1:0]       count_next;
    logic                            do_push;
    logic                            do_take;

    assign full    = (count_reg == dmt_pkg::QCntW'(dmt_pkg::QDepth));
    assign do_push = push && !full;
    assign do_take = take && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == dmt_pkg::QPtrW'(dmt_pkg::QDepth - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_take)
        begin
            rd_ptr_next = (rd_ptr_reg == dmt_pkg::QPtrW'(dmt_pkg::QDepth - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_take && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    `DMT_ASSERT_ALWAYS(a_count_bound, clk, rst_n,
        count_reg <= dmt_pkg::QCntW'(dmt_pkg::QDepth))
    `DMT_ASSERT_NEXT(a_take_drops, clk, rst_n, do_take && !do_push,
        count_reg == $past(count_reg) - 1'b1)
    `DMT_ASSERT_NEXT(a_push_adds, clk, rst_n, do_push && !do_take,
        count_reg == $past(count_reg) + 1'b1)

endmodule

>>> sv/dmt_back.sv
// ---------------------------------------------------------------------------
// dmt_back
// slot sequencer: preamble, sixteen data half-bits, trailer; unless the result stalls, one per cycle
// ---------------------------------------------------------------------------
`include "differential_manchester_transmitter_defines.svh"

module dmt_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dmt_pkg::head_t        head,
    output logic                  take,
    output logic                  empty,
    input  logic                  pop,
    output logic                  line_level,
    output logic                  run_end
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PRE0,
        ST_PRE1,
        ST_DATA,
        ST_TRAIL
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [dmt_pkg::DataW-1:0]      data_reg;
    logic [dmt_pkg::DataW-1:0]      data_next;
    logic                           last_reg;
    logic                           last_next;
    logic [dmt_pkg::BitIdxW-1:0]    idx_reg;
    logic [dmt_pkg::BitIdxW-1:0]    idx_next;
    logic                           half_reg;
    logic                           half_next;
    logic                           level_reg;
    logic                           level_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           line_level_reg;
    logic                           line_level_next;
    logic                           run_end_reg;
    logic                           run_end_next;

    logic                           advance;
    logic                           emit;
    logic                           slot_last;
    logic                           slot_level;
    logic                           first_half;

    assign advance = !out_valid_reg || pop;
    assign emit    = advance && (state_reg != ST_IDLE);

    // a one keeps the level at the boundary, a zero flips it
    assign first_half = level_reg ^ ~data_reg[idx_reg];

    always_comb
    begin
        slot_last  = 1'b0;
        slot_level = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                slot_level = 1'b0;
            end
            ST_PRE0:
            begin
                slot_level = 1'b0;
            end
            ST_PRE1:
            begin
                slot_level = 1'b1;
            end
            ST_DATA:
            begin
                slot_level = half_reg ? ~level_reg : first_half;
                slot_last  = half_reg && (idx_reg == '0) && !last_reg;
            end
            ST_TRAIL:
            begin
                slot_level = 1'b0;
                slot_last  = 1'b1;
            end
            default:
            begin
                slot_level = 1'b0;
            end
        endcase
    end

    // next item starts as soon as the current one hands out its last slot
    assign take = advance && ((state_reg == ST_IDLE) || slot_last) && head.valid;

    always_comb
    begin
        state_next      = state_reg;
        data_next       = data_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        half_next       = half_reg;
        level_next      = level_reg;
        out_valid_next  = out_valid_reg;
        line_level_next = line_level_reg;
        run_end_next    = run_end_reg;

        if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (emit)
        begin
            out_valid_next  = 1'b1;
            line_level_next = slot_level;
            run_end_next    = slot_last;
            unique case (state_reg)
                ST_PRE0:
                begin
                    state_next = ST_PRE1;
                end
                ST_PRE1:
                begin
                    state_next = ST_DATA;
                    level_next = 1'b1;
                end
                ST_DATA:
                begin
                    if (half_reg)
                    begin
                        level_next = ~level_reg;
                        half_next  = 1'b0;
                        if (idx_reg == '0)
                        begin
                            state_next = last_reg ? ST_TRAIL : ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        level_next = first_half;
                        half_next  = 1'b1;
                    end
                end
                ST_TRAIL:
                begin
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        if (take)
        begin
            data_next  = head.item.data_byte;
            last_next  = head.item.last_byte;
            idx_next   = dmt_pkg::BitIdxW'(dmt_pkg::TopBit);
            half_next  = 1'b0;
            state_next = head.item.first_byte ? ST_PRE0 : ST_DATA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            data_reg       <= '0;
            last_reg       <= 1'b0;
            idx_reg        <= '0;
            half_reg       <= 1'b0;
            level_reg      <= 1'b1;
            out_valid_reg  <= 1'b0;
            line_level_reg <= 1'b0;
            run_end_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            data_reg       <= data_next;
            last_reg       <= last_next;
            idx_reg        <= idx_next;
            half_reg       <= half_next;
            level_reg      <= level_next;
            out_valid_reg  <= out_valid_next;
            line_level_reg <= line_level_next;
            run_end_reg    <= run_end_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign line_level = line_level_reg;
    assign run_end    = run_end_reg;

    `DMT_ASSERT_NEXT(a_mid_bit_flip, clk, rst_n,
        emit && (state_reg == ST_DATA) && half_reg,
        line_level_reg == !$past(line_level_reg))
    `DMT_ASSERT_NEXT(a_trailer_low, clk, rst_n, emit && (state_reg == ST_TRAIL),
        !line_level_reg && run_end_reg)
    `DMT_ASSERT_NEXT(a_preamble_high, clk, rst_n, emit && (state_reg == ST_PRE1),
        level_reg && line_level_reg)
    `DMT_ASSERT_NEXT(a_take_starts, clk, rst_n, take,
        (state_reg == ST_PRE0) || (state_reg == ST_DATA))

endmodule

>>> sv/differential_manchester_transmitter.sv
// ---------------------------------------------------------------------------
// differential_manchester_transmitter
// message bytes in, one differential manchester line level per half-bit out
// ---------------------------------------------------------------------------
//  channel   handshake        payload
//  input     push / full      data_byte[7:0], first_byte, last_byte
//  result    pop / empty      line_level, run_end
//
//  one slot per cycle from the back-end sequencer unless the result stalls: 16 slots
//  per byte, plus 2 for a preamble and 1 for a trailer (16 to 19)
//  a two-entry item queue lets bytes arrive while the previous byte is sent
//  reset: queue empty, no result waiting, end level high
//  a stalled result holds the sequencer; input stalls only when the queue fills
// ---------------------------------------------------------------------------
module differential_manchester_transmitter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [dmt_pkg::DataW-1:0]     data_byte,
    input  logic                          first_byte,
    input  logic                          last_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic                          line_level,
    output logic                          run_end
);

    dmt_pkg::item_t  item_in;
    dmt_pkg::head_t  head;
    logic            take;

    assign item_in.data_byte  = data_byte;
    assign item_in.first_byte = first_byte;
    assign item_in.last_byte  = last_byte;

    dmt_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item_in (item_in),
        .head    (head),
        .take    (take)
    );

    dmt_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .take       (take),
        .empty      (empty),
        .pop        (pop),
        .line_level (line_level),
        .run_end    (run_end)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// differential manchester transmitter: message bytes are pushed with random
// framing and pacing; each half-bit line slot is checked against a typed
// directed row or a local encoder tracking level across bytes and messages
// ---------------------------------------------------------------------------
module tb_top;

    localparam int MaxSlots   = 19;
    localparam int RandBytes  = 200;
    localparam int CycleLimit = 200000;
    localparam int DirN       = 21;

    typedef struct packed {
        logic line_level;
        logic run_end;
    } slot_t;

    // directed row; when typed, lv holds the slot levels left-aligned
    typedef struct {
        logic [dmt_pkg::DataW-1:0] data;
        logic                      first;
        logic                      last;
        bit                        typed;
        int                        n;
        logic [MaxSlots-1:0]       lv;
    } row_t;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      push       = 1'b0;
    logic                      full;
    logic [dmt_pkg::DataW-1:0] data_byte  = '0;
    logic                      first_byte = 1'b0;
    logic                      last_byte  = 1'b0;
    logic                      empty;
    logic                      pop        = 1'b0;
    logic                      line_level;
    logic                      run_end;

    slot_t pending_slots[$];
    logic  tx_level = 1'b1;
    row_t  dir_rows [DirN];

    int errors        = 0;
    int bytes_sent    = 0;
    int preambles     = 0;
    int trailers      = 0;
    int slots_checked = 0;
    int cycles        = 0;
    int rx_cyc        = 0;
    int burst_left    = 0;

    differential_manchester_transmitter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .empty      (empty),
        .pop        (pop),
        .line_level (line_level),
        .run_end    (run_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // encodes one byte into left-aligned slot levels, returns the slot count
    function automatic int encode_byte(input logic [dmt_pkg::DataW-1:0] d, input logic f,
                                       input logic l, output logic [MaxSlots-1:0] lv);
        int   n;
        logic half;
        n  = 0;
        lv = '0;
        if (f)
        begin
            lv[MaxSlots-1] = 1'b0;
            lv[MaxSlots-2] = 1'b1;
            n              = 2;
            tx_level       = 1'b1;
        end
        for (int b = dmt_pkg::TopBit; b >= 0; b--)
        begin
            // a one keeps the level at the boundary, a zero flips it
            half                 = d[b] ? tx_level : ~tx_level;
            lv[MaxSlots-1-n]     = half;
            lv[MaxSlots-2-n]     = ~half;
            n                    = n + 2;
            tx_level             = ~half;
        end
        // trailer slot is low but leaves the kept level alone
        if (l)
        begin
            lv[MaxSlots-1-n] = 1'b0;
            n                = n + 1;
        end
        return n;
    endfunction

    function automatic logic [dmt_pkg::DataW-1:0] pick_byte();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [dmt_pkg::DataW-1:0] d, input logic f,
                             input logic l, input bit typed, input int tn,
                             input logic [MaxSlots-1:0] tlv);
        int                  gap;
        int                  n;
        logic [MaxSlots-1:0] lv;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push       <= 1'b1;
        data_byte  <= d;
        first_byte <= f;
        last_byte  <= l;
        // full is sampled as it stood before the edge
        do @(posedge clk); while (full);
        n = encode_byte(d, f, l, lv);
        if (typed)
        begin
            n  = tn;
            lv = tlv;
        end
        for (int k = 0; k < n; k++)
            pending_slots.push_back('{line_level: lv[MaxSlots-1-k], run_end: (k == n - 1)});
        bytes_sent++;
        if (f)
            preambles++;
        if (l)
            trailers++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_slots.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int  sent;
        int  len;
        bit  mid_drained;
        sent        = 0;
        mid_drained = 0;

        dir_rows = '{
            // right after reset: zeros flip the high level at each bit boundary
            '{8'h00, 1'b0, 1'b0, 1'b1, 16, {16'b0101010101010101, 3'b000}},
            // single-byte message of ones
            '{8'hFF, 1'b1, 1'b1, 1'b1, 19, {2'b01, 16'b1001100110011001, 1'b0}},
            // no preamble after a message end
            '{8'h00, 1'b0, 1'b0, 1'b1, 16, {16'b0101010101010101, 3'b000}},
            '{8'h80, 1'b1, 1'b0, 1'b1, 18, {2'b01, 16'b1010101010101010, 1'b0}},
            '{8'h01, 1'b0, 1'b1, 1'b1, 17, {16'b1010101010101001, 1'b0, 2'b00}},
            '{8'h55, 1'b0, 1'b0, 1'b0, 0, '0},
            '{8'hAA, 1'b0, 1'b0, 1'b0, 0, '0},
            '{8'h7F, 1'b1, 1'b0, 1'b0, 0, '0},
            '{8'hFE, 1'b0, 1'b0, 1'b0, 0, '0},
            '{8'h0F, 1'b0, 1'b1, 1'b0, 0, '0},
            '{8'hF0, 1'b1, 1'b1, 1'b0, 0, '0},
            '{8'h00, 1'b0, 1'b1, 1'b0, 0, '0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, 0, '0},
            '{8'hA5, 1'b0, 1'b0, 1'b0, 0, '0},
            '{8'h3C, 1'b1, 1'b0, 1'b0, 0, '0},
            '{8'hC3, 1'b0, 1'b1, 1'b0, 0, '0},
            '{8'h81, 1'b1, 1'b1, 1'b0, 0, '0},
            '{8'h18, 1'b0, 1'b0, 1'b0, 0, '0},
            '{8'h01, 1'b0, 1'b0, 1'b0, 0, '0},
            '{8'h80, 1'b1, 1'b0, 1'b0, 0, '0},
            '{8'hFF, 1'b1, 1'b1, 1'b0, 0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DirN; i++)
            send_byte(dir_rows[i].data, dir_rows[i].first, dir_rows[i].last,
                      dir_rows[i].typed, dir_rows[i].n, dir_rows[i].lv);
        drain();

        // mostly framed messages, some loose bytes with random flags
        while (sent < RandBytes)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    send_byte(pick_byte(), k == 0, k == len - 1, 1'b0, 0, '0);
                sent = sent + len;
            end
            else
            begin
                send_byte(pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'b0, 0, '0);
                sent++;
            end
            if (!mid_drained && sent >= RandBytes / 2)
            begin
                drain();
                mid_drained = 1;
            end
        end
        drain();
        repeat (40) @(posedge clk);

        if (pending_slots.size() != 0)
        begin
            $error("%0d slots never came out", pending_slots.size());
            errors++;
        end
        $display("%0d bytes sent, %0d opening a message, %0d closing one",
                 bytes_sent, preambles, trailers);
        $display("%0d line slots compared under random input gaps and output stalls",
                 slots_checked);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // output side: check each popped slot, then pick the next pop
    always @(posedge clk)
    begin
        slot_t exp_slot;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_slots.size() == 0)
                begin
                    $error("unexpected slot: line_level %0b run_end %0b", line_level, run_end);
                    errors++;
                end
                else
                begin
                    exp_slot = pending_slots.pop_front();
                    slots_checked++;
                    if (line_level !== exp_slot.line_level)
                    begin
                        $error("line_level: expected %0b, got %0b",
                               exp_slot.line_level, line_level);
                        errors++;
                    end
                    if (run_end !== exp_slot.run_end)
                    begin
                        $error("run_end: expected %0b, got %0b", exp_slot.run_end, run_end);
                        errors++;
                    end
                end
            end
            rx_cyc++;
            case ((rx_cyc / 400) % 4)
                0:       pop <= 1'b1;
                1:       pop <= ($urandom_range(0, 3) != 0);
                2:       pop <= ($urandom_range(0, 1) != 0);
                default: pop <= ((rx_cyc % 23) < 5);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d slots still pending",
                     cycles, pending_slots.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

>>> files.f
+incdir+sv
sv/dmt_pkg.sv
sv/dmt_front.sv
sv/dmt_back.sv
sv/differential_manchester_transmitter.sv
tb/tb_top.sv
